// ----- rtl/core/gtp_pkg.sv -----
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and the arctangent table for the go-to-point
// wheel controller pipeline.
// ----------------------------------------------------------------------------
package gtp_pkg;

	localparam int FRAC_BITS = 12;
	localparam int ANG_FRAC  = 28;
	localparam int CW        = 34;
	localparam int WW        = CW + 2;
	localparam int ERR_W     = 32;
	localparam int SQ_W      = 34;
	localparam int ROOT_W    = 17;
	localparam int REM_W     = 20;

	localparam logic signed [CW-1:0] ANG_PI      = 34'sd843314857;
	localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd421657428;
	localparam logic signed [CW-1:0] INV_GAIN    = 34'sd163008218;

	localparam logic signed [WW-1:0] ANG_PI_W      = 36'sd843314857;
	localparam logic signed [WW-1:0] ANG_TWO_PI_W  = 36'sd1686629713;
	localparam logic signed [WW-1:0] ANG_FOUR_PI_W = 36'sd3373259426;

	typedef enum logic [2:0] {
		REG_ANG_GAIN  = 3'd0,
		REG_LIN_GAIN  = 3'd1,
		REG_ANG_LIMIT = 3'd2,
		REG_LIN_LIMIT = 3'd3,
		REG_ARRIVE    = 3'd4,
		REG_RADIUS    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                 far;
		logic                 neg;
		logic signed [CW-1:0] ang;
	} side_t;

	typedef struct packed {
		logic                 valid;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		side_t                side;
	} cordic_t;

	typedef struct packed {
		logic [SQ_W-1:0]   n;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	function automatic logic signed [CW-1:0] atan_entry(input int idx);
		logic signed [CW-1:0] r;
		unique case (idx)
			0:  r = 34'sd210828714;
			1:  r = 34'sd124459457;
			2:  r = 34'sd65760959;
			3:  r = 34'sd33381290;
			4:  r = 34'sd16755422;
			5:  r = 34'sd8385879;
			6:  r = 34'sd4193963;
			7:  r = 34'sd2097109;
			8:  r = 34'sd1048571;
			9:  r = 34'sd524287;
			10: r = 34'sd262144;
			11: r = 34'sd131072;
			12: r = 34'sd65536;
			13: r = 34'sd32768;
			14: r = 34'sd16384;
			15: r = 34'sd8192;
			16: r = 34'sd4096;
			17: r = 34'sd2048;
			18: r = 34'sd1024;
			19: r = 34'sd512;
			20: r = 34'sd256;
			21: r = 34'sd128;
			22: r = 34'sd64;
			23: r = 34'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/gtp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// gtp_cordic_cell
// One micro-rotation of a CORDIC chain, vectoring or rotation mode, with a
// registered output and sideband carried along.
// ----------------------------------------------------------------------------
module gtp_cordic_cell
	import gtp_pkg::*;
#(
	parameter int STAGE  = 0,
	parameter bit VECTOR = 1'b1
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  cordic_t din,
	output cordic_t dout
);

	logic signed [CW-1:0] sh_x, sh_y, ang;
	logic                 up;
	cordic_t              nxt;
	cordic_t              data_q;
	logic                 valid_q;

	always_comb begin
		sh_x = din.x >>> STAGE;
		sh_y = din.y >>> STAGE;
		ang  = atan_entry(STAGE);
		up   = VECTOR ? ~din.y[CW-1] : din.z[CW-1];
		nxt  = din;
		if (up) begin
			nxt.x = din.x + sh_y;
			nxt.y = din.y - sh_x;
			nxt.z = din.z + ang;
		end else begin
			nxt.x = din.x - sh_y;
			nxt.y = din.y + sh_x;
			nxt.z = din.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end

endmodule

// ----- rtl/core/gtp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// gtp_sqrt_cell
// One bit of a restoring integer square root; two radicand bits enter per
// cell and one root bit leaves.
// ----------------------------------------------------------------------------
module gtp_sqrt_cell
	import gtp_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  sqrt_t din,
	output sqrt_t dout
);

	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;
	sqrt_t            data_q;

	always_comb begin
		rem_sh = {din.rem[REM_W-3:0], din.n[SQ_W-1 -: 2]};
		trial  = {{(REM_W-ROOT_W-2){1'b0}}, din.root, 2'b01};
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.n    <= {din.n[SQ_W-3:0], 2'b00};
			data_q.rem  <= ge ? (rem_sh - trial) : rem_sh;
			data_q.root <= {din.root[ROOT_W-2:0], ge};
		end
	end

	assign dout = data_q;

endmodule

// ----- rtl/core/go_to_point_wheel_controller_unit.sv -----
// ----------------------------------------------------------------------------
// go_to_point_wheel_controller_unit
// Differential-drive go-to-goal controller: bearing, distance, heading error
// and wheel speed commands in Q4.12.
// ----------------------------------------------------------------------------
// One pose is accepted and one result leaves per clock unless the output
// stalls. Poses pass the vectoring and rotation CORDIC chains and the speed
// multipliers. The distance square root runs as a parallel chain of 17
// cells. The pipeline halts only while its last stage and the output
// register both hold results that have not been taken. Registers are to be
// written only while the block is idle; the block does not enforce this.
module go_to_point_wheel_controller_unit
	import gtp_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_speed,
	output logic signed [15:0] right_speed,
	output logic               arrived
);

	localparam int DLY = 2 * CORDIC_STAGES - 16;

	function automatic logic signed [15:0] clamp_mag(input logic signed [65:0] v,
		input logic [14:0] lim);
		logic signed [65:0] l;
		logic signed [15:0] r;
		l = $signed({51'd0, lim});
		if (v > l) r = l[15:0];
		else if (v < -l) r = 16'(-l);
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [29:0] v);
		logic signed [15:0] r;
		if (v > 30'sd32767) r = 16'sh7FFF;
		else if (v < -30'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	// configuration
	logic [15:0] ang_gain_q, lin_gain_q;
	logic [14:0] ang_lim_q, lin_lim_q, tol_q;
	logic [11:0] radius_q;
	logic [29:0] tol_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_gain_q <= 16'd2304;
			lin_gain_q <= 16'd333;
			ang_lim_q  <= 15'd12288;
			lin_lim_q  <= 15'd2458;
			tol_q      <= 15'd287;
			radius_q   <= 12'd0;
			tol_sq_q   <= 30'd82369;
		end else begin
			tol_sq_q <= tol_q * tol_q;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ANG_GAIN:  ang_gain_q <= cfg_data;
					REG_LIN_GAIN:  lin_gain_q <= cfg_data;
					REG_ANG_LIMIT: ang_lim_q  <= cfg_data[14:0];
					REG_LIN_LIMIT: lin_lim_q  <= cfg_data[14:0];
					REG_ARRIVE:    tol_q      <= cfg_data[14:0];
					REG_RADIUS:    radius_q   <= cfg_data[11:0];
					default: ;
				endcase
			end
		end
	end

	// flow control
	logic en, out_load, valid_s6;
	logic out_valid_q;

	assign en       = !(valid_s6 && out_valid_q && !out_ready);
	assign out_load = !out_valid_q || out_ready;
	assign in_ready = en;

	// s1: differences
	logic               valid_s1, valid_s2;
	logic signed [16:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [15:0] head_s1, head_s2;
	logic [SQ_W-1:0]    dxx_s2, dyy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= 17'(target_x) - 17'(pose_x);
			dy_s1   <= 17'(target_y) - 17'(pose_y);
			head_s1 <= pose_heading;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			head_s2 <= head_s1;
			dxx_s2  <= SQ_W'($signed(dx_s1) * $signed(dx_s1));
			dyy_s2  <= SQ_W'($signed(dy_s1) * $signed(dy_s1));
		end
	end

	// chain inputs
	logic [SQ_W-1:0]      sq;
	logic signed [CW-1:0] xs, ys;
	cordic_t              vec_c [CORDIC_STAGES+1];
	cordic_t              rot_c [CORDIC_STAGES+1];
	sqrt_t                sq_c  [ROOT_W+1];

	always_comb begin
		sq = dxx_s2 + dyy_s2;
		xs = {{(CW-29){dx_s2[16]}}, dx_s2, 12'd0};
		ys = {{(CW-29){dy_s2[16]}}, dy_s2, 12'd0};
		vec_c[0].valid     = valid_s2;
		vec_c[0].side.far  = (sq > SQ_W'(tol_sq_q));
		vec_c[0].side.neg  = 1'b0;
		vec_c[0].side.ang  = {{(CW-32){head_s2[15]}}, head_s2, 16'd0};
		if (dx_s2[16]) begin
			vec_c[0].x = -xs;
			vec_c[0].y = -ys;
			vec_c[0].z = dy_s2[16] ? -ANG_PI : ANG_PI;
		end else begin
			vec_c[0].x = xs;
			vec_c[0].y = ys;
			vec_c[0].z = '0;
		end
		sq_c[0].n    = sq;
		sq_c[0].rem  = '0;
		sq_c[0].root = '0;
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		gtp_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .din(vec_c[i]), .dout(vec_c[i+1])
		);
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		gtp_sqrt_cell u_cell (
			.clk(clk), .en(en), .din(sq_c[i]), .dout(sq_c[i+1])
		);
	end

	// distance aligned with the end of the rotation chain
	logic [ROOT_W-1:0] d_dly;

	if (DLY == 0) begin : g_nodly
		assign d_dly = sq_c[ROOT_W].root;
	end else begin : g_dly
		logic [ROOT_W-1:0] d_q [DLY];
		always_ff @(posedge clk) begin
			if (en) begin
				d_q[0] <= sq_c[ROOT_W].root;
				for (int k = 1; k < DLY; k++) begin
					d_q[k] <= d_q[k-1];
				end
			end
		end
		assign d_dly = d_q[DLY-1];
	end

	// s3: heading error wrap
	logic signed [CW-1:0]    a_diff;
	logic signed [WW-1:0]    m_w, cand, err_full;
	logic                    valid_s3, far_s3;
	logic signed [ERR_W-1:0] err_s3;

	always_comb begin
		a_diff = vec_c[CORDIC_STAGES].z - vec_c[CORDIC_STAGES].side.ang;
		m_w    = {{2{a_diff[CW-1]}}, a_diff} + ANG_PI_W;
		priority if (m_w >= ANG_FOUR_PI_W) cand = m_w - ANG_FOUR_PI_W;
		else if (m_w >= ANG_TWO_PI_W) cand = m_w - ANG_TWO_PI_W;
		else if (m_w >= 0) cand = m_w;
		else if (m_w >= -ANG_TWO_PI_W) cand = m_w + ANG_TWO_PI_W;
		else cand = m_w + ANG_FOUR_PI_W;
		err_full = cand - ANG_PI_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= vec_c[CORDIC_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3 <= err_full[ERR_W-1:0];
			far_s3 <= vec_c[CORDIC_STAGES].side.far;
		end
	end

	// rotation chain for the cosine
	logic signed [CW-1:0] z0;

	always_comb begin
		z0                = {{(CW-ERR_W){err_s3[ERR_W-1]}}, err_s3};
		rot_c[0].valid    = valid_s3;
		rot_c[0].x        = INV_GAIN;
		rot_c[0].y        = '0;
		rot_c[0].side.far = far_s3;
		rot_c[0].side.ang = z0;
		priority if (z0 > ANG_HALF_PI) begin
			rot_c[0].z        = z0 - ANG_PI;
			rot_c[0].side.neg = 1'b1;
		end else if (z0 < -ANG_HALF_PI) begin
			rot_c[0].z        = z0 + ANG_PI;
			rot_c[0].side.neg = 1'b1;
		end else begin
			rot_c[0].z        = z0;
			rot_c[0].side.neg = 1'b0;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		gtp_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .din(rot_c[i]), .dout(rot_c[i+1])
		);
	end

	// s4..s6: speeds
	cordic_t                 co;
	logic signed [ERR_W-1:0] err_c;
	logic signed [CW-1:0]    cos_v;
	logic                    valid_s4, valid_s5, far_s4, far_s5, far_s6;
	logic signed [31:0]      cos_s4;
	logic signed [48:0]      wf_s4;
	logic [32:0]             gd_s4;
	logic signed [49:0]      pplo_s5;
	logic signed [48:0]      pphi_s5;
	logic signed [15:0]      w_s5, v_s6;
	logic signed [28:0]      turn_s6;
	logic signed [48:0]      wr;
	logic signed [65:0]      vfull, vr;

	always_comb begin
		co    = rot_c[CORDIC_STAGES];
		err_c = co.side.ang[ERR_W-1:0];
		cos_v = co.side.neg ? -co.x : co.x;
		wr    = (wf_s4 + 49'sd8388608) >>> 24;
		vfull = ($signed({{17{pphi_s5[48]}}, pphi_s5}) <<< 17)
			+ $signed({{16{pplo_s5[49]}}, pplo_s5});
		vr    = (vfull + (66'sd1 <<< 35)) >>> 36;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= co.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s4  <= cos_v[31:0];
			wf_s4   <= $signed({1'b0, ang_gain_q}) * err_c;
			gd_s4   <= lin_gain_q * d_dly;
			far_s4  <= co.side.far;
			pplo_s5 <= $signed({1'b0, gd_s4[16:0]}) * cos_s4;
			pphi_s5 <= $signed({1'b0, gd_s4[32:17]}) * cos_s4;
			w_s5    <= clamp_mag({{17{wr[48]}}, wr}, ang_lim_q);
			far_s5  <= far_s4;
			v_s6    <= clamp_mag(vr, lin_lim_q);
			turn_s6 <= $signed({1'b0, radius_q}) * w_s5;
			far_s6  <= far_s5;
		end
	end

	// output register
	logic signed [28:0] tr;
	logic signed [29:0] lsum, rsum;
	logic signed [15:0] left_q, right_q;
	logic               arrived_q;

	always_comb begin
		tr   = (turn_s6 + 29'sd2048) >>> 12;
		lsum = 30'(v_s6) - 30'(tr);
		rsum = 30'(v_s6) + 30'(tr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q    <= far_s6 ? sat16(lsum) : 16'sd0;
			right_q   <= far_s6 ? sat16(rsum) : 16'sd0;
			arrived_q <= !far_s6;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_speed  = left_q;
	assign right_speed = right_q;
	assign arrived     = arrived_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a waiting result");

	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && arrived) |-> (left_speed == 16'sd0 && right_speed == 16'sd0))
		else $error("arrived transaction with nonzero speed");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ($signed({{(CW-ERR_W){err_s3[ERR_W-1]}}, err_s3}) >= -ANG_PI
			&& $signed({{(CW-ERR_W){err_s3[ERR_W-1]}}, err_s3}) < ANG_PI))
		else $error("heading error out of range");

	a_w_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (w_s5 <= $signed({1'b0, ang_lim_q})
			&& w_s5 >= -$signed({1'b0, ang_lim_q})))
		else $error("angular speed beyond limit");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the go-to-point wheel controller. Poses and targets are sent
// over a valid/ready channel with random gaps, wheel commands are taken with
// random stalls, and every transaction is checked against a bit-exact
// fixed-point predictor with CORDIC bearing, cosine and integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import gtp_pkg::*;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               arr;
	} wheel_cmd_t;

	localparam longint PI_Q28     = 843314857;
	localparam longint TWO_PI_Q28 = 1686629713;
	localparam longint HALF_PI_Q28 = 421657428;
	localparam longint INV_GAIN_Q28 = 163008218;
	localparam int     N_STAGES   = 16;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] target_x = '0;
	logic signed [15:0] target_y = '0;
	logic signed [15:0] pose_x = '0;
	logic signed [15:0] pose_y = '0;
	logic signed [15:0] pose_heading = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	logic               arrived;

	longint     k_ang_gain, k_lin_gain, k_ang_lim, k_lin_lim, k_tol, k_arm;
	wheel_cmd_t cmd_queue[$];
	int         n_fail = 0;
	int         hold_cycles = 0;
	bit         quiet_out = 1'b0;

	go_to_point_wheel_controller_unit u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >= 0 ? (v >>> s) : (-1 - ((-1 - v) >>> s));
	endfunction

	function automatic longint round_shr(longint v, int s);
		return floor_shr(v + (longint'(1) << (s - 1)), s);
	endfunction

	function automatic longint sat_s16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic longint clamp_by_mag(longint v, longint lim);
		longint m;
		m = v < 0 ? -v : v;
		if (m > lim)
			return v > 0 ? lim : -lim;
		return v;
	endfunction

	function automatic longint floor_sqrt(longint n);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint wrap_pi(longint a);
		longint m;
		m = (a + PI_Q28) % TWO_PI_Q28;
		if (m < 0)
			m += TWO_PI_Q28;
		return m - PI_Q28;
	endfunction

	function automatic longint atan_q28(int i);
		return longint'(atan_entry(i));
	endfunction

	function automatic longint bearing_q28(longint dy, longint dx);
		longint x, y, z, nx;
		x = dx * 4096;
		y = dy * 4096;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q28 : -PI_Q28;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < N_STAGES; i++) begin
			if (y < 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= atan_q28(i);
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += atan_q28(i);
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic longint cosine_q28(longint a);
		longint x, y, z, nx;
		bit flip;
		x = INV_GAIN_Q28;
		y = 0;
		z = a;
		flip = 1'b0;
		if (z > HALF_PI_Q28) begin
			z -= PI_Q28;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q28) begin
			z += PI_Q28;
			flip = 1'b1;
		end
		for (int i = 0; i < N_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= atan_q28(i);
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += atan_q28(i);
			end
			x = nx;
		end
		return flip ? -x : x;
	endfunction

	function automatic wheel_cmd_t predict_wheels(logic signed [15:0] tx, logic signed [15:0] ty,
			logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] hd);
		wheel_cmd_t c;
		longint dx, dy, sq, d, err, w, v, turn;
		dx = longint'(tx) - longint'(px);
		dy = longint'(ty) - longint'(py);
		sq = dx * dx + dy * dy;
		c.left = '0;
		c.right = '0;
		c.arr = 1'b1;
		if (sq > k_tol * k_tol) begin
			d = floor_sqrt(sq);
			err = wrap_pi(bearing_q28(dy, dx) - longint'(hd) * 65536);
			w = round_shr(k_ang_gain * err, 24);
			v = round_shr(k_lin_gain * d * cosine_q28(err), 36);
			w = clamp_by_mag(w, k_ang_lim);
			v = clamp_by_mag(v, k_lin_lim);
			turn = round_shr(k_arm * w, 12);
			c.left = 16'(sat_s16(v - turn));
			c.right = 16'(sat_s16(v + turn));
			c.arr = 1'b0;
		end
		return c;
	endfunction

	// valid stays up after a transaction so the next one can follow directly
	task automatic send_pose(logic signed [15:0] tx, logic signed [15:0] ty,
			logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] hd);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= hd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cmd_queue.push_back(predict_wheels(tx, ty, px, py, hd));
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			REG_ANG_GAIN: k_ang_gain = val;
			REG_LIN_GAIN: k_lin_gain = val;
			REG_ANG_LIMIT: k_ang_lim = val & 16'h7fff;
			REG_LIN_LIMIT: k_lin_lim = val & 16'h7fff;
			REG_ARRIVE: k_tol = val & 16'h7fff;
			REG_RADIUS: k_arm = val & 16'h0fff;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (cmd_queue.size() != 0)
			@(negedge clk);
		repeat (2 * N_STAGES + 12) @(negedge clk);
	endtask

	task automatic set_gains(logic [15:0] ag, logic [15:0] lg, logic [15:0] al,
			logic [15:0] ll, logic [15:0] tol, logic [15:0] arm);
		wait_drained();
		write_reg(REG_ANG_GAIN, ag);
		write_reg(REG_LIN_GAIN, lg);
		write_reg(REG_ANG_LIMIT, al);
		write_reg(REG_LIN_LIMIT, ll);
		write_reg(REG_ARRIVE, tol);
		write_reg(REG_RADIUS, arm);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 400)) - 16'd200;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		set_gains(16'd2304, 16'd333, 16'd12288, 16'd2458, 16'd287, 16'd1200);
		send_pose(0, 0, 0, 0, 0);
		send_pose(16'sd287, 0, 0, 0, 0);
		send_pose(16'sd288, 0, 0, 0, 0);
		send_pose(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 0);
		send_pose(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_pose(-16'sd4096, 0, 0, 0, 0);
		send_pose(-16'sd4096, -16'sd1, 0, 0, 0);
		send_pose(-16'sd4096, 0, 0, 0, -16'sh8000);
		send_pose(0, 16'sd4096, 0, 0, 16'sh7fff);
		send_pose(0, -16'sd4096, 0, 0, 16'sd12868);
		send_pose(16'sd4096, 16'sd4096, 0, 0, -16'sd12868);
		send_pose(16'sd100, -16'sd8000, 16'sd50, 0, 16'sd6434);
	endtask

	task automatic test_extreme_gains();
		set_gains(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'd0, 16'h0fff);
		send_pose(0, 0, 0, 0, 0);
		send_pose(0, 16'sd1, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send_pose(rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
		set_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0);
		send_pose(16'sh7fff, 0, 0, 0, 0);
		send_pose(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 0);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_pose(rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
	endtask

	task automatic test_random_config();
		for (int p = 0; p < 6; p++) begin
			set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(0, 2000)), 16'($urandom));
			test_random(180);
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		test_random(120);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (quiet_out) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		wheel_cmd_t e;
		if (arst_n && out_valid && out_ready) begin
			if (cmd_queue.size() == 0) begin
				$error("unexpected transaction");
				n_fail++;
			end else begin
				e = cmd_queue.pop_front();
				if (left_speed !== e.left) begin
					$error("left_speed exp %0d got %0d", e.left, left_speed);
					n_fail++;
				end
				if (right_speed !== e.right) begin
					$error("right_speed exp %0d got %0d", e.right, right_speed);
					n_fail++;
				end
				if (arrived !== e.arr) begin
					$error("arrived exp %0d got %0d", e.arr, arrived);
					n_fail++;
				end
			end
		end
	end

	initial begin
		k_ang_gain = 2304;
		k_lin_gain = 333;
		k_ang_lim = 12288;
		k_lin_lim = 2458;
		k_tol = 287;
		k_arm = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_pose(16'sd1000, 16'sd500, 0, 0, 0);
		test_directed();
		test_extreme_gains();
		test_backpressure();
		quiet_out = 1'b1;
		test_random(60);
		quiet_out = 1'b0;
		test_random_config();
		set_gains(16'd2304, 16'd333, 16'd12288, 16'd2458, 16'd287, 16'd0);
		test_random(100);
		wait_drained();
		if (n_fail == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
